FILE: rtl/timed_obstacle_avoidance_fsm_macros.svh
// Assertion macros for the timed obstacle avoidance controller.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef TIMED_OBSTACLE_AVOIDANCE_FSM_MACROS_SVH
`define TIMED_OBSTACLE_AVOIDANCE_FSM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TOA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TOA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/toa_pkg.sv
// Shared types, constants and helpers for the obstacle avoidance controller.
// No dependencies; all other RTL files but the macros header use this package.
`default_nettype none

package toa_pkg;

  // Default sizes
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned DIST_BITS_DEF = 10;

  // Register and field widths
  localparam int unsigned SAFE_W     = 10;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // A zero distance reading means no echo; treat it as this far away
  localparam int unsigned NO_ECHO_CM = 300;

  // Register reset values
  localparam logic [SAFE_W-1:0]  SAFE_DIST_RST      = SAFE_W'(15);
  localparam logic [SPEED_W-1:0] FWD_PWM_RST        = SPEED_W'(200);
  localparam logic [SPEED_W-1:0] TURN_PWM_RST       = SPEED_W'(180);
  localparam logic [SPEED_W-1:0] BACKUP_SPEED_RST   = SPEED_W'(180);
  localparam logic [DUR_W-1:0]   TURN_MS_RST        = DUR_W'(300);
  localparam logic [DUR_W-1:0]   BACKUP_MS_RST      = DUR_W'(300);
  localparam logic [DUR_W-1:0]   SECOND_TURN_MS_RST = DUR_W'(400);

  typedef enum logic [ACT_W-1:0] {
    ACT_STOP  = 3'd0,
    ACT_FWD   = 3'd1,
    ACT_RIGHT = 3'd2,
    ACT_LEFT  = 3'd3,
    ACT_BACK  = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAFE_DIST      = 3'd0,
    CFG_FWD_PWM        = 3'd1,
    CFG_TURN_PWM       = 3'd2,
    CFG_BACKUP_SPEED   = 3'd3,
    CFG_TURN_MS        = 3'd4,
    CFG_BACKUP_MS      = 3'd5,
    CFG_SECOND_TURN_MS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SAFE_W-1:0]  block_dist;
    logic [SPEED_W-1:0] fwd_pwm;
    logic [SPEED_W-1:0] turn_pwm;
    logic [SPEED_W-1:0] backup_speed;
    logic [DUR_W-1:0]   turn_ms;
    logic [DUR_W-1:0]   backup_ms;
    logic [DUR_W-1:0]   second_turn_ms;
  } cfg_t;

  typedef struct packed {
    action_e            action;
    logic [SPEED_W-1:0] speed;
    logic               issued;
  } res_t;

  // Motor PWM for a given action
  function automatic logic [SPEED_W-1:0] speed_of(action_e act, cfg_t cfg);
    logic [SPEED_W-1:0] sp;
    case (act)
      ACT_FWD:   sp = cfg.fwd_pwm;
      ACT_RIGHT: sp = cfg.turn_pwm;
      ACT_LEFT:  sp = cfg.turn_pwm;
      ACT_BACK:  sp = cfg.backup_speed;
      default:   sp = '0;
    endcase
    return sp;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/toa_in_if.sv
// Input channel: one control pass (time and two distances) per beat.
// Depends on toa_pkg for default sizes.
`default_nettype none

interface toa_in_if #(
  parameter int unsigned TIME_BITS = toa_pkg::TIME_BITS_DEF,
  parameter int unsigned DIST_BITS = toa_pkg::DIST_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_ms;
  logic [DIST_BITS-1:0] left_cm;
  logic [DIST_BITS-1:0] right_cm;

  modport source (output valid, now_ms, left_cm, right_cm, input ready);
  modport sink   (input valid, now_ms, left_cm, right_cm, output ready);
endinterface

`default_nettype wire

FILE: rtl/toa_out_if.sv
// Output channel: one motor command result per beat.
// Depends on toa_pkg for field widths.
`default_nettype none

interface toa_out_if;
  logic                        valid;
  logic                        ready;
  logic [toa_pkg::ACT_W-1:0]   action;
  logic [toa_pkg::SPEED_W-1:0] left_speed;
  logic [toa_pkg::SPEED_W-1:0] right_speed;
  logic                        command_issued;

  modport source (output valid, action, left_speed, right_speed, command_issued,
                  input ready);
  modport sink   (input valid, action, left_speed, right_speed, command_issued,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/toa_cfg.sv
// Configuration register file: thresholds, speeds and durations.
// Depends on toa_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module toa_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               we_i,
  input  wire logic [toa_pkg::CFG_IDX_W-1:0]      idx_i,
  input  wire logic [toa_pkg::CFG_DATA_W-1:0]     wdata_i,
  output toa_pkg::cfg_t                           cfg_o
);
  import toa_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_SAFE_DIST:      cfg_d.block_dist     = wdata_i[SAFE_W-1:0];
        CFG_FWD_PWM:        cfg_d.fwd_pwm        = wdata_i[SPEED_W-1:0];
        CFG_TURN_PWM:       cfg_d.turn_pwm       = wdata_i[SPEED_W-1:0];
        CFG_BACKUP_SPEED:   cfg_d.backup_speed   = wdata_i[SPEED_W-1:0];
        CFG_TURN_MS:        cfg_d.turn_ms        = wdata_i[DUR_W-1:0];
        CFG_BACKUP_MS:      cfg_d.backup_ms      = wdata_i[DUR_W-1:0];
        CFG_SECOND_TURN_MS: cfg_d.second_turn_ms = wdata_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_dist     <= SAFE_DIST_RST;
      cfg_q.fwd_pwm        <= FWD_PWM_RST;
      cfg_q.turn_pwm       <= TURN_PWM_RST;
      cfg_q.backup_speed   <= BACKUP_SPEED_RST;
      cfg_q.turn_ms        <= TURN_MS_RST;
      cfg_q.backup_ms      <= BACKUP_MS_RST;
      cfg_q.second_turn_ms <= SECOND_TURN_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/toa_core.sv
// Decision logic and controller state (current action, deadline, queued action).
// Depends on toa_pkg; state advances once per pass when step_i is high.
`default_nettype none

module toa_core #(
  parameter int unsigned TIME_BITS = toa_pkg::TIME_BITS_DEF,
  parameter int unsigned DIST_BITS = toa_pkg::DIST_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire logic [DIST_BITS-1:0] left_i,
  input  wire logic [DIST_BITS-1:0] right_i,
  input  wire toa_pkg::cfg_t        cfg_i,
  output toa_pkg::res_t             res_o
);
  import toa_pkg::*;

  // Compare width covers the distance port, the threshold and the no-echo value
  localparam int unsigned CMP_BITS = (DIST_BITS > SAFE_W) ? DIST_BITS : SAFE_W;

  action_e              cur_q, cur_d, pend_q, pend_d, cur_eff;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic [DUR_W-1:0]     pdur_q, pdur_d, dur;
  logic                 use_timer, issued, timed, running;
  logic [CMP_BITS-1:0]  left_eff, right_eff, safe_ext;
  logic                 lclear, rclear;

  // No-echo substitution and threshold compare
  assign left_eff  = (left_i == '0)  ? CMP_BITS'(NO_ECHO_CM) : CMP_BITS'(left_i);
  assign right_eff = (right_i == '0) ? CMP_BITS'(NO_ECHO_CM) : CMP_BITS'(right_i);
  assign safe_ext  = CMP_BITS'(cfg_i.block_dist);
  assign lclear    = left_eff > safe_ext;
  assign rclear    = right_eff > safe_ext;

  // Next state for one pass
  always_comb begin
    timed     = dl_q != '0;
    running   = timed && (now_i < dl_q);
    cur_eff   = timed ? ACT_STOP : cur_q;
    cur_d     = cur_q;
    dl_d      = dl_q;
    pend_d    = pend_q;
    pdur_d    = pdur_q;
    issued    = 1'b0;
    dur       = '0;
    use_timer = 1'b0;
    if (!running) begin
      if (timed && (pend_q != ACT_STOP)) begin
        // expired with a queued action: start it and finish the pass
        cur_d     = pend_q;
        dur       = pdur_q;
        use_timer = 1'b1;
        pend_d    = ACT_STOP;
        pdur_d    = '0;
        issued    = 1'b1;
      end else begin
        // expired (stop issued) or untimed: decide from the distances
        cur_d  = cur_eff;
        dl_d   = '0;
        issued = timed;
        if (lclear && rclear) begin
          if (cur_eff != ACT_FWD) begin
            cur_d  = ACT_FWD;
            issued = 1'b1;
          end
        end else if (!lclear && rclear) begin
          cur_d     = ACT_RIGHT;
          dur       = cfg_i.turn_ms;
          use_timer = 1'b1;
          issued    = 1'b1;
        end else if (lclear) begin
          cur_d     = ACT_LEFT;
          dur       = cfg_i.turn_ms;
          use_timer = 1'b1;
          issued    = 1'b1;
        end else begin
          cur_d     = ACT_BACK;
          dur       = cfg_i.backup_ms;
          use_timer = 1'b1;
          pend_d    = ACT_RIGHT;
          pdur_d    = cfg_i.second_turn_ms;
          issued    = 1'b1;
        end
      end
    end
    // zero duration, or a sum that wraps to zero, leaves the action untimed
    if (use_timer) begin
      dl_d = (dur != '0) ? (now_i + TIME_BITS'(dur)) : '0;
    end
  end

  // Result of this pass
  always_comb begin
    res_o.action = cur_d;
    res_o.speed  = speed_of(cur_d, cfg_i);
    res_o.issued = issued;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= ACT_STOP;
      dl_q   <= '0;
      pend_q <= ACT_STOP;
      pdur_q <= '0;
    end else if (step_i) begin
      cur_q  <= cur_d;
      dl_q   <= dl_d;
      pend_q <= pend_d;
      pdur_q <= pdur_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/timed_obstacle_avoidance_fsm.sv
// Channel  | Dir | Fields                                          | Beat
// ---------+-----+-------------------------------------------------+-------------------
// in_i     | in  | now_ms, left_cm, right_cm                       | one control pass
// out_o    | out | action, left_speed, right_speed, command_issued | one motor result
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i                | one register write
//
// Path: an input beat is held in the input register, its result in the result register.
// Throughput: one pass per cycle unless out_o stalls; one compare stage and one deadline adder.
// Reset: asynchronous, clears the controller state and loads the register defaults.
// Stalls: a stalled result holds the output register; the input register keeps taking a
// beat whenever it is empty or moves into the output register in the same cycle.
`default_nettype none
`include "timed_obstacle_avoidance_fsm_macros.svh"

module timed_obstacle_avoidance_fsm #(
  parameter int unsigned TIME_BITS = toa_pkg::TIME_BITS_DEF,
  parameter int unsigned DIST_BITS = toa_pkg::DIST_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  toa_in_if.sink                              in_i,
  toa_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [toa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [toa_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import toa_pkg::*;

  cfg_t                 cfg;
  res_t                 res, out_res_q;
  logic                 s1_valid_q, out_valid_q, adv, in_fire;
  logic                 s1_stall, out_stop;
  logic [TIME_BITS-1:0] s1_now_q;
  logic [DIST_BITS-1:0] s1_left_q, s1_right_q;

  // Handshake: the pass moves on when the result register is free or draining
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_fire    = in_i.valid && in_i.ready;

  toa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  toa_core #(
    .TIME_BITS (TIME_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .now_i   (s1_now_q),
    .left_i  (s1_left_q),
    .right_i (s1_right_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_now_q   <= in_i.now_ms;
      s1_left_q  <= in_i.left_cm;
      s1_right_q <= in_i.right_cm;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.action         = out_res_q.action;
  assign out_o.left_speed     = out_res_q.speed;
  assign out_o.right_speed    = out_res_q.speed;
  assign out_o.command_issued = out_res_q.issued;

  // Checks
  assign s1_stall = s1_valid_q && !adv;
  assign out_stop = out_valid_q && (out_res_q.action == ACT_STOP);

  `TOA_ASSERT_NEXT(a_pass_held, clk_i, rst_ni, s1_stall, s1_valid_q, "pass lost in stall")
  `TOA_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, adv, out_valid_q, "pass left no result")
  `TOA_ASSERT_NOW(a_stop_idle, clk_i, rst_ni, out_stop, out_res_q.speed == '0, "speed on stop")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking bench for the timed obstacle avoidance controller.
// Needs toa_pkg, toa_in_if, toa_out_if and timed_obstacle_avoidance_fsm.
module tb;
  import toa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned NUM_REGS     = 7;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;  // no register here

  typedef struct {
    action_e            action;
    logic [SPEED_W-1:0] left_pwm;
    logic [SPEED_W-1:0] right_pwm;
    logic               issued;
  } motor_cmd_t;

  // Tracks controller state and checks each motor result against its pass
  class avoid_scoreboard;
    cfg_t               regs;
    action_e            cur_act;
    action_e            queued_act;
    logic [31:0]        deadline;
    logic [DUR_W-1:0]   queued_dur;
    motor_cmd_t         cmd_q[$];
    int unsigned        n_errors;
    int unsigned        n_passes;
    int unsigned        n_checked;
    int unsigned        n_issued;

    function new();
      regs.block_dist     = SAFE_DIST_RST;
      regs.fwd_pwm        = FWD_PWM_RST;
      regs.turn_pwm       = TURN_PWM_RST;
      regs.backup_speed   = BACKUP_SPEED_RST;
      regs.turn_ms        = TURN_MS_RST;
      regs.backup_ms      = BACKUP_MS_RST;
      regs.second_turn_ms = SECOND_TURN_MS_RST;
      cur_act    = ACT_STOP;
      queued_act = ACT_STOP;
      deadline   = '0;
      queued_dur = '0;
      n_errors   = 0;
      n_passes   = 0;
      n_checked  = 0;
      n_issued   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SAFE_DIST:      regs.block_dist     = data[SAFE_W-1:0];
        CFG_FWD_PWM:        regs.fwd_pwm        = data[SPEED_W-1:0];
        CFG_TURN_PWM:       regs.turn_pwm       = data[SPEED_W-1:0];
        CFG_BACKUP_SPEED:   regs.backup_speed   = data[SPEED_W-1:0];
        CFG_TURN_MS:        regs.turn_ms        = data[DUR_W-1:0];
        CFG_BACKUP_MS:      regs.backup_ms      = data[DUR_W-1:0];
        CFG_SECOND_TURN_MS: regs.second_turn_ms = data[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SPEED_W-1:0] pwm_for(action_e act);
      case (act)
        ACT_FWD:             return regs.fwd_pwm;
        ACT_RIGHT, ACT_LEFT: return regs.turn_pwm;
        ACT_BACK:            return regs.backup_speed;
        default:             return '0;
      endcase
    endfunction

    // Zero duration, or a sum that wraps to zero, leaves the action untimed
    function void start_action(action_e act, logic [DUR_W-1:0] dur, logic [31:0] now);
      cur_act  = act;
      deadline = (dur != 0) ? now + 32'(dur) : '0;
    endfunction

    function void note_pass(logic [31:0] now, logic [9:0] left_cm, logic [9:0] right_cm);
      logic       issued;
      logic       decided;
      logic [9:0] lv;
      logic [9:0] rv;
      logic       lclr;
      logic       rclr;
      motor_cmd_t cmd;
      issued  = 1'b0;
      decided = 1'b0;
      n_passes++;
      // timed action: hold until deadline, then run the queued action or stop
      if (deadline != 0) begin
        if (now < deadline) begin
          decided = 1'b1;
        end else begin
          deadline = '0;
          if (queued_act != ACT_STOP) begin
            start_action(queued_act, queued_dur, now);
            queued_act = ACT_STOP;
            queued_dur = '0;
            issued     = 1'b1;
            decided    = 1'b1;
          end else begin
            start_action(ACT_STOP, '0, now);
            issued = 1'b1;
          end
        end
      end
      if (!decided) begin
        lv   = (left_cm == 0) ? 10'(NO_ECHO_CM) : left_cm;
        rv   = (right_cm == 0) ? 10'(NO_ECHO_CM) : right_cm;
        lclr = lv > regs.block_dist;
        rclr = rv > regs.block_dist;
        if (lclr && rclr) begin
          if (cur_act != ACT_FWD) begin
            start_action(ACT_FWD, '0, now);
            issued = 1'b1;
          end
        end else if (!lclr && rclr) begin
          start_action(ACT_RIGHT, regs.turn_ms, now);
          issued = 1'b1;
        end else if (lclr && !rclr) begin
          start_action(ACT_LEFT, regs.turn_ms, now);
          issued = 1'b1;
        end else begin
          start_action(ACT_BACK, regs.backup_ms, now);
          queued_act = ACT_RIGHT;
          queued_dur = regs.second_turn_ms;
          issued     = 1'b1;
        end
      end
      cmd.action    = cur_act;
      cmd.left_pwm  = pwm_for(cur_act);
      cmd.right_pwm = pwm_for(cur_act);
      cmd.issued    = issued;
      if (issued) n_issued++;
      cmd_q.push_back(cmd);
    endfunction

    function void check_result(logic [ACT_W-1:0] act, logic [SPEED_W-1:0] lspd,
                               logic [SPEED_W-1:0] rspd, logic issued);
      motor_cmd_t want;
      if (cmd_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: action=%0d left=%0d right=%0d issued=%0b",
                   $time, act, lspd, rspd, issued);
        return;
      end
      want = cmd_q.pop_front();
      n_checked++;
      if (act !== want.action || lspd !== want.left_pwm || rspd !== want.right_pwm ||
          issued !== want.issued) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("[%0t] mismatch: expected action=%0d left=%0d right=%0d issued=%0b",
                   $time, want.action, want.left_pwm, want.right_pwm, want.issued);
          $display("          actual   action=%0d left=%0d right=%0d issued=%0b",
                   act, lspd, rspd, issued);
        end
      end
    endfunction

    function int unsigned pending_results();
      return cmd_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic [CFG_DATA_W-1:0] reg_vals [NUM_REGS];
  bit                    gaps_on;
  int unsigned           hold_reqs;
  int unsigned           holds_done;
  int unsigned           n_settings;
  int unsigned           cycle_cnt;
  avoid_scoreboard       sb;

  toa_in_if  in_if ();
  toa_out_if out_if ();

  timed_obstacle_avoidance_fsm DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Beat monitor: results checked, accepted passes fed to the predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.action, out_if.left_speed, out_if.right_speed,
                        out_if.command_issued);
      if (in_if.valid && in_if.ready)
        sb.note_pass(in_if.now_ms, in_if.left_cm, in_if.right_cm);
    end
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_reqs != holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (gaps_on) begin
        out_if.ready <= ($urandom_range(0, 99) >= 25);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // One pass beat, with random idle cycles ahead of it
  task automatic send_pass(input logic [31:0] now, input logic [9:0] left_cm,
                           input logic [9:0] right_cm);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.now_ms   <= now;
    in_if.left_cm  <= left_cm;
    in_if.right_cm <= right_cm;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_results() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input bit touch_unused);
    for (int i = 0; i < NUM_REGS; i++)
      write_one(CFG_IDX_W'(i), reg_vals[i]);
    if (touch_unused)
      write_one(CFG_IDX_NONE, 16'hFFFF);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Random register set; upper junk bits check masking
  task automatic roll_regs();
    reg_vals[CFG_SAFE_DIST]      = {6'($urandom), 10'($urandom_range(5, 300))};
    reg_vals[CFG_FWD_PWM]        = 16'($urandom);
    reg_vals[CFG_TURN_PWM]       = 16'($urandom);
    reg_vals[CFG_BACKUP_SPEED]   = 16'($urandom);
    reg_vals[CFG_TURN_MS]        = ($urandom_range(0, 4) == 0) ? 16'd0 :
                                   16'($urandom_range(1, 1000));
    reg_vals[CFG_BACKUP_MS]      = ($urandom_range(0, 4) == 0) ? 16'd0 :
                                   16'($urandom_range(1, 1000));
    reg_vals[CFG_SECOND_TURN_MS] = ($urandom_range(0, 4) == 0) ? 16'd0 :
                                   16'($urandom_range(1, 1000));
  endtask

  // Distances cluster around the threshold so both sides flip often
  function automatic logic [9:0] pick_range();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 15) return '0;
    if (sel < 55) begin
      v = int'(sb.regs.block_dist) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return 10'(v);
    end
    if (sel < 85) return 10'($urandom_range(int'(sb.regs.block_dist), 1023));
    return 10'($urandom);
  endfunction

  // Mostly forward-moving time; some passes are pure noise
  task automatic run_traffic(input int unsigned n_items, input logic [31:0] start_ms,
                             input int unsigned max_step);
    logic [31:0] clock_ms;
    clock_ms = start_ms;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_pass($urandom, 10'($urandom), 10'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0)
          clock_ms = clock_ms + $urandom_range(0, max_step * 8);
        else
          clock_ms = clock_ms + $urandom_range(0, max_step);
        send_pass(clock_ms, pick_range(), pick_range());
      end
    end
  endtask

  initial begin
    sb              = new();
    rst_n           = 1'b0;
    cycle_cnt       = 0;
    gaps_on         = 1'b1;
    hold_reqs       = 0;
    holds_done      = 0;
    n_settings      = 1;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.now_ms    = '0;
    in_if.left_cm   = '0;
    in_if.right_cm  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed walk at reset settings: every action, expiry, queued turn, wrap
    send_pass(32'd100, 10'd0, 10'd0);                 // no echo both sides: forward
    send_pass(32'd101, 10'd500, 10'd600);             // forward already, quiet
    send_pass(32'd102, 10'd10, 10'd500);              // left blocked: turn right
    send_pass(32'd250, 10'd1, 10'd1);                 // still turning
    send_pass(32'd402, 10'd500, 10'd500);             // expiry: stop then forward
    send_pass(32'd403, 10'd700, 10'd15);              // right at threshold: turn left
    send_pass(32'd703, 10'd15, 10'd15);               // both blocked: back up
    send_pass(32'd1002, 10'd1023, 10'd1023);
    send_pass(32'd1003, 10'd1023, 10'd1023);          // queued right turn starts
    send_pass(32'd1403, 10'd16, 10'd16);
    send_pass(32'd1404, 10'd16, 10'd16);
    send_pass(32'd1500, 10'd1, 10'd1);
    send_pass(32'hFFFF_FFFF, 10'd1023, 10'd0);        // deadline wraps past zero
    send_pass(32'd200, 10'd5, 10'd5);
    send_pass(32'd399, 10'd0, 10'd15);
    send_pass(32'd699, 10'd700, 10'd700);
    send_pass(32'hFFFF_FED4, 10'd5, 10'd800);         // deadline wraps to exactly zero
    send_pass(32'hFFFF_FED5, 10'd800, 10'd800);
    send_pass(32'd0, 10'd800, 10'd5);
    send_pass(32'd0, 10'd800, 10'd800);
    send_pass(32'hAAAA_5555, 10'h2AA, 10'h155);
    send_pass(32'h5555_AAAA, 10'h155, 10'h2AA);
    drain();

    // Reset settings, no idling on either side
    gaps_on = 1'b0;
    run_traffic(120, 32'd5000, 120);
    drain();
    gaps_on = 1'b1;

    // Top of every register range
    reg_vals[CFG_SAFE_DIST]      = 16'hFFFF;
    reg_vals[CFG_FWD_PWM]        = 16'hFFFF;
    reg_vals[CFG_TURN_PWM]       = 16'h00FF;
    reg_vals[CFG_BACKUP_SPEED]   = 16'hFFFF;
    reg_vals[CFG_TURN_MS]        = 16'hFFFF;
    reg_vals[CFG_BACKUP_MS]      = 16'hFFFF;
    reg_vals[CFG_SECOND_TURN_MS] = 16'hFFFF;
    program_regs(1'b1);
    run_traffic(90, $urandom, 8000);
    drain();

    // Bottom of every range; junk above the threshold field
    reg_vals[CFG_SAFE_DIST]      = 16'hFC00;
    reg_vals[CFG_FWD_PWM]        = 16'hFF00;
    reg_vals[CFG_TURN_PWM]       = 16'h0000;
    reg_vals[CFG_BACKUP_SPEED]   = 16'h0000;
    reg_vals[CFG_TURN_MS]        = 16'h0000;
    reg_vals[CFG_BACKUP_MS]      = 16'h0000;
    reg_vals[CFG_SECOND_TURN_MS] = 16'h0000;
    program_regs(1'b0);
    run_traffic(60, 32'd0, 200);
    drain();

    // Random settings; one starts near time wrap, one holds the result side off
    for (int p = 0; p < 4; p++) begin
      roll_regs();
      program_regs(1'b0);
      if (p == 1) hold_reqs++;
      run_traffic(120, (p == 2) ? 32'hFFFF_E000 : 32'($urandom_range(0, 1 << 20)), 120);
      drain();
    end

    drain();
    $display("Ran %0d control passes over %0d register settings, incl. a long result stall.",
             sb.n_passes, n_settings);
    $display("Checked %0d results; %0d carried a motor command; %0d mismatches.",
             sb.n_checked, sb.n_issued, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_results() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
